>>> sv/line_rasterizer_core_macros.svh
// assertion macros shared by the line rasterizer modules
`ifndef LINE_RASTERIZER_CORE_MACROS_SVH
`define LINE_RASTERIZER_CORE_MACROS_SVH

// same-cycle implication, checked on every clk edge outside reset
`define LRC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every clk edge outside reset
`define LRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/lr_pkg.sv
// shared types for the line rasterizer: controller states and command/status groups
`timescale 1ns / 1ps

package lr_pkg;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_STEP = 3'b010,
		S_SPARE = 3'b100
	} lr_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
	} lr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
	} lr_stat_t;

endpackage

>>> sv/line_rasterizer_core.sv
// line rasterizer top level: bresenham segment to pixel stream
// Usage:
//   in channel (in_valid/in_ready) takes one segment: start_x, start_y, end_x, end_y.
//   out channel (out_valid/out_ready) gives every pixel of it in stepping order,
//   pixel_x, pixel_y, pixel_color, with last_pixel high on the final one.
//   cfg_we/cfg_wdata write draw_color, copied onto each pixel; write it only while idle.
// Timing:
//   once a segment item is accepted the controller moves to its stepping state, and each
//   step loads a pixel into the result register, one pixel per cycle while out_ready is high;
//   a segment gives N pixels, where N is the major-axis length plus one, at most 64.
//   in_ready is high only between segments, in the cycle after the last pixel is
//   stepped, so a new segment is not taken until the last one is fully stepped; the
//   stepper and its single result register set this limit.
// Reset:
//   arst_n clears the controller, the result valid and draw_color; no item is held.
// Stall:
//   while out_ready is low the pending pixel holds and the stepper waits,
//   resuming on the cycle the pixel is taken.
`timescale 1ns / 1ps

module line_rasterizer_core #(
	parameter int COORD_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [23:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [23:0]           pixel_color,
	output logic                  last_pixel
);

	lr_pkg::lr_cmd_t  cmd;
	lr_pkg::lr_stat_t stat;

	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	lr_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule

>>> sv/lr_dp.sv
// line rasterizer datapath: segment setup, bresenham stepper and result register
`timescale 1ns / 1ps
`include "line_rasterizer_core_macros.svh"

module lr_dp #(
	parameter int COORD_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lr_pkg::lr_cmd_t       cmd,
	output lr_pkg::lr_stat_t      stat,
	input  logic                  cfg_we,
	input  logic [23:0]           cfg_wdata,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [23:0]           pixel_color,
	output logic                  last_pixel
);

	localparam int C     = COORD_BITS;
	localparam int INC_W = COORD_BITS + 1;
	localparam int ACC_W = COORD_BITS + 3;

	logic [23:0]            draw_color_q;
	logic [C-1:0]           major_pos_q, minor_pos_q, major_end_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [INC_W-1:0]       major_inc_q, minor_inc_q;
	logic                   steep_q, mdown_q, ndown_q;

	logic [C-1:0]           pixel_x_q, pixel_y_q;
	logic [23:0]            pixel_color_q;
	logic                   last_pixel_q;

	// setup
	logic                   swap, xdown, steep;
	logic [C-1:0]           x0, y0, x1, y1, adx, dy, mdelta, ndelta;
	logic [INC_W-1:0]       minc, ninc;
	logic signed [ACC_W-1:0] acc_init;

	// stepping
	logic                   acc_pos, at_end;
	logic signed [ACC_W-1:0] acc_a, acc_n;

	always_comb begin
		swap = end_y < start_y;
		x0 = swap ? end_x : start_x;
		y0 = swap ? end_y : start_y;
		x1 = swap ? start_x : end_x;
		y1 = swap ? start_y : end_y;
		xdown = x1 <= x0;
		adx = xdown ? (x0 - x1) : (x1 - x0);
		dy = y1 - y0;
		steep = dy > adx;
		mdelta = steep ? dy : adx;
		ndelta = steep ? adx : dy;
		minc = {ndelta, 1'b0};
		ninc = {mdelta, 1'b0};
		acc_init = $signed({2'b00, minc}) - $signed({3'b000, mdelta});
	end

	always_comb begin
		acc_pos = !acc_q[ACC_W-1] && (acc_q != '0);
		acc_a = acc_pos ? (acc_q - $signed({2'b00, minor_inc_q})) : acc_q;
		acc_n = acc_a + $signed({2'b00, major_inc_q});
		at_end = major_pos_q == major_end_q;
	end

	assign stat.last = at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q <= '0;
		end else if (cfg_we) begin
			draw_color_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			major_pos_q <= steep ? y0 : x0;
			minor_pos_q <= steep ? x0 : y0;
			major_end_q <= steep ? y1 : x1;
			acc_q <= acc_init;
			major_inc_q <= minc;
			minor_inc_q <= ninc;
			steep_q <= steep;
			mdown_q <= steep ? 1'b0 : xdown;
			ndown_q <= steep ? xdown : 1'b0;
		end else if (cmd.step && !at_end) begin
			if (acc_pos) begin
				minor_pos_q <= ndown_q ? (minor_pos_q - C'(1)) : (minor_pos_q + C'(1));
			end
			major_pos_q <= mdown_q ? (major_pos_q - C'(1)) : (major_pos_q + C'(1));
			acc_q <= acc_n;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			pixel_x_q <= steep_q ? minor_pos_q : major_pos_q;
			pixel_y_q <= steep_q ? major_pos_q : minor_pos_q;
			pixel_color_q <= draw_color_q;
			last_pixel_q <= at_end;
		end
	end

	assign pixel_x = pixel_x_q;
	assign pixel_y = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign last_pixel = last_pixel_q;

	`LRC_ASSERT_NEXT(a_major_moves, cmd.step && !at_end && !cmd.load, major_pos_q != $past(major_pos_q), "major axis did not advance")
	`LRC_ASSERT_NEXT(a_last_flag, cmd.step, last_pixel_q == $past(at_end), "last flag does not match end test")
	`LRC_ASSERT_NEXT(a_steep_up, cmd.load, !(steep_q && mdown_q), "steep segment set to step down in y")

endmodule

>>> sv/lr_ctrl.sv
// line rasterizer controller: segment sequencing and result handshake
`timescale 1ns / 1ps
`include "line_rasterizer_core_macros.svh"

module lr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lr_pkg::lr_cmd_t   cmd,
	input  lr_pkg::lr_stat_t  stat
);

	lr_pkg::lr_state_t state_q, state_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = state_q == lr_pkg::S_IDLE;
	assign cmd.load = in_valid && in_ready;
	assign cmd.step = (state_q == lr_pkg::S_STEP) && out_free;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lr_pkg::S_IDLE: begin
				if (cmd.load) state_d = lr_pkg::S_STEP;
			end
			lr_pkg::S_STEP: begin
				if (cmd.step && stat.last) state_d = lr_pkg::S_IDLE;
			end
			default: state_d = lr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lr_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a pixel waits in the result register until taken
			if (cmd.step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`LRC_ASSERT_NEXT(a_load_steps, cmd.load, state_q == lr_pkg::S_STEP, "segment load did not start stepping")
	`LRC_ASSERT_NEXT(a_last_idles, cmd.step && stat.last, state_q == lr_pkg::S_IDLE, "last pixel did not end segment")
	`LRC_ASSERT_IMP(a_valid_src, $rose(out_valid_q), $past(cmd.step), "result valid without a step")

endmodule
